// ----- rtl/mts_pkg.sv -----
package mts_pkg;

  // Fixed field widths of the beats
  localparam int unsigned ValueW  = 32;
  localparam int unsigned DepthW  = 11;
  localparam int unsigned StatusW = 2;

  // Operation codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] current_max;
    logic                     is_empty;
    logic [DepthW-1:0]        depth_used;
    logic [StatusW-1:0]       status;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_RELOAD
  } state_t;

endpackage

// ----- rtl/mts_ram.sv -----
module mts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/max_tracking_stack_top.sv -----
// Channel | Dir | Handshake             | Beat
// --------+-----+-----------------------+---------------------------------------------
// in      | in  | in_valid / in_ready   | kind, value (push or pop)
// out     | out | out_valid / out_ready | current_max, is_empty, depth_used, status
//
// A push, a dropped push and an ignored pop are answered from the idle state; a pop
// that removes a value passes through the reload state, where the registered reads of
// the value and maxima memories refill the cached top entries.
// Reset clears the state, the counts and the output valid flag; the memories are not
// cleared, and an unwritten entry read when a pop empties a stack reaches no output.
// The result waits in an output register; a new beat is taken while it drains.
module max_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_item_t out_data
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned VW = mts_pkg::ValueW;

  mts_pkg::state_t state, state_next;

  logic [CW-1:0]          vc, vc_next;
  logic [CW-1:0]          mc, mc_next;
  logic signed [VW-1:0]   top_val, top_val_next;
  logic signed [VW-1:0]   top_max, top_max_next;
  logic                   pop_max, pop_max_next;
  logic                   out_valid_next;
  mts_pkg::out_item_t     out_data_next;

  logic                   accept;
  logic                   is_push;
  logic                   push_ok;
  logic                   pop_ok;
  logic                   max_push;
  logic                   top_is_max;
  logic [CW-1:0]          vc_less2;
  logic [CW-1:0]          mc_less2;
  logic signed [VW-1:0]   reload_max;

  logic                   val_we;
  logic                   max_we;
  logic [AW-1:0]          val_raddr;
  logic [AW-1:0]          max_raddr;
  logic [VW-1:0]          val_rdata;
  logic [VW-1:0]          max_rdata;

  // Decode the incoming beat against the cached top
  assign accept     = in_valid && in_ready;
  assign is_push    = (in_data.kind == mts_pkg::KIND_PUSH);
  assign push_ok    = (vc != CW'(STACK_DEPTH));
  assign pop_ok     = (vc != '0);
  assign max_push   = ((mc == '0) || (in_data.value >= top_max)) && (mc != CW'(STACK_DEPTH));
  assign top_is_max = (mc != '0) && (top_val == top_max);
  assign vc_less2   = vc - CW'(2);
  assign mc_less2   = mc - CW'(2);
  assign reload_max = pop_max ? $signed(max_rdata) : top_max;

  // Memory ports: pushes write at the counts, pops read the entry below the top
  assign val_we    = accept && is_push && push_ok;
  assign max_we    = val_we && max_push;
  assign val_raddr = vc_less2[AW-1:0];
  assign max_raddr = mc_less2[AW-1:0];

  mts_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (vc[AW-1:0]),
    .wdata (in_data.value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  mts_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (mc[AW-1:0]),
    .wdata (in_data.value),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mts_pkg::ST_IDLE: begin
        if (accept && !is_push && pop_ok) begin
          state_next = mts_pkg::ST_RELOAD;
        end
      end
      mts_pkg::ST_RELOAD: begin
        state_next = mts_pkg::ST_IDLE;
      end
      default: begin
        state_next = mts_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready       = (state == mts_pkg::ST_IDLE) && (!out_valid || out_ready);
    vc_next        = vc;
    mc_next        = mc;
    top_val_next   = top_val;
    top_max_next   = top_max;
    pop_max_next   = pop_max;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    case (state)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_push) begin
            out_valid_next = 1'b1;
            if (push_ok) begin
              vc_next      = vc + CW'(1);
              top_val_next = in_data.value;
              if (max_push) begin
                mc_next      = mc + CW'(1);
                top_max_next = in_data.value;
              end
              out_data_next.current_max = max_push ? in_data.value : top_max;
              out_data_next.is_empty    = 1'b0;
              out_data_next.depth_used  = mts_pkg::DepthW'(vc + CW'(1));
              out_data_next.status      = mts_pkg::STATUS_OK;
            end else begin
              out_data_next.current_max = (mc != '0) ? top_max : '0;
              out_data_next.is_empty    = 1'b0;
              out_data_next.depth_used  = mts_pkg::DepthW'(vc);
              out_data_next.status      = mts_pkg::STATUS_OVERFLOW;
            end
          end else if (pop_ok) begin
            // Drop the top; refill the cached tops next cycle
            vc_next      = vc - CW'(1);
            pop_max_next = top_is_max;
            if (top_is_max) begin
              mc_next = mc - CW'(1);
            end
          end else begin
            out_valid_next            = 1'b1;
            out_data_next.current_max = '0;
            out_data_next.is_empty    = 1'b1;
            out_data_next.depth_used  = mts_pkg::DepthW'(vc);
            out_data_next.status      = mts_pkg::STATUS_UNDERFLOW;
          end
        end
      end
      mts_pkg::ST_RELOAD: begin
        top_val_next              = $signed(val_rdata);
        top_max_next              = reload_max;
        out_valid_next            = 1'b1;
        out_data_next.current_max = ((vc != '0) && (mc != '0)) ? reload_max : '0;
        out_data_next.is_empty    = (vc == '0);
        out_data_next.depth_used  = mts_pkg::DepthW'(vc);
        out_data_next.status      = mts_pkg::STATUS_OK;
      end
      default: begin
        out_valid_next = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mts_pkg::ST_IDLE;
      vc        <= '0;
      mc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      vc        <= vc_next;
      mc        <= mc_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_val  <= top_val_next;
    top_max  <= top_max_next;
    pop_max  <= pop_max_next;
    out_data <= out_data_next;
  end

endmodule

// ----- tb/max_tracking_stack_top_test.sv -----
`timescale 1ns / 1ps

module max_tracking_stack_top_test;

  localparam int unsigned StackDepth    = 1024;
  localparam int unsigned IdlePct       = 31;
  localparam int unsigned QuietFirst    = 500;
  localparam int unsigned QuietLast     = 700;
  localparam int unsigned HoldOffAt     = 300;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned MaxReports    = 10;

  localparam logic signed [mts_pkg::ValueW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [mts_pkg::ValueW-1:0] ValMin = 32'sh8000_0000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mts_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mts_pkg::out_item_t out_data;

  max_tracking_stack_top #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the value stack and the maxima stack
  logic signed [mts_pkg::ValueW-1:0] shadow_vals [StackDepth];
  logic signed [mts_pkg::ValueW-1:0] shadow_maxes[StackDepth];
  int unsigned n_vals  = 0;
  int unsigned n_maxes = 0;

  // Beats waiting to be sent, with a flag to wait for an empty pipeline first
  mts_pkg::in_item_t  pending_beats[$];
  bit                 pending_drain[$];
  mts_pkg::out_item_t expected_results[$];

  int unsigned        plan_depth   = 0;
  int unsigned        beats_sent   = 0;
  int unsigned        results_seen = 0;
  int unsigned        fail_count   = 0;
  int unsigned        hold_left    = 0;
  int unsigned        idle_cycles  = 0;
  bit                 held_once    = 1'b0;
  bit                 send_now;
  mts_pkg::out_item_t want;

  // Apply one push or pop to the shadow stacks and return the resulting beat
  function automatic mts_pkg::out_item_t step_stack(mts_pkg::in_item_t beat);
    mts_pkg::out_item_t res;
    res        = '0;
    res.status = mts_pkg::STATUS_OK;
    if (beat.kind == mts_pkg::KIND_PUSH) begin
      if (n_vals >= StackDepth) begin
        res.status = mts_pkg::STATUS_OVERFLOW;
      end else begin
        shadow_vals[n_vals] = beat.value;
        n_vals++;
        if (n_maxes == 0 || beat.value >= shadow_maxes[n_maxes-1]) begin
          if (n_maxes < StackDepth) begin
            shadow_maxes[n_maxes] = beat.value;
            n_maxes++;
          end
        end
      end
    end else begin
      if (n_vals == 0) begin
        res.status = mts_pkg::STATUS_UNDERFLOW;
      end else begin
        // Drop the top maximum only when the popped value is that maximum
        if (n_maxes > 0 && shadow_vals[n_vals-1] == shadow_maxes[n_maxes-1]) n_maxes--;
        n_vals--;
      end
    end
    res.current_max = (n_vals > 0 && n_maxes > 0) ? shadow_maxes[n_maxes-1] : '0;
    res.is_empty    = (n_vals == 0);
    res.depth_used  = n_vals[mts_pkg::DepthW-1:0];
    return res;
  endfunction

  // Mix extremes, a narrow band that produces repeated maxima, and full-range values
  function automatic logic signed [mts_pkg::ValueW-1:0] pick_value();
    logic signed [mts_pkg::ValueW-1:0] v;
    int unsigned roll;
    roll = $urandom_range(9);
    case (roll)
      0: v = ValMax;
      1: v = ValMin;
      2, 3, 4, 5: begin
        v = $urandom_range(16);
        v = v - 8;
      end
      6: v = ValMax - $urandom_range(3);
      7: v = ValMin + $urandom_range(3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_beat(input logic kind,
                            input logic signed [mts_pkg::ValueW-1:0] value,
                            input bit drain);
    mts_pkg::in_item_t b;
    b.kind  = kind;
    b.value = value;
    pending_beats.push_back(b);
    pending_drain.push_back(drain);
    if (kind == mts_pkg::KIND_PUSH) begin
      if (plan_depth < StackDepth) plan_depth++;
    end else if (plan_depth > 0) begin
      plan_depth--;
    end
  endtask

  task automatic queue_random(input int unsigned push_pct, input bit drain);
    logic kind;
    kind = ($urandom_range(99) < push_pct) ? mts_pkg::KIND_PUSH : mts_pkg::KIND_POP;
    queue_beat(kind, pick_value(), drain);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: present pending beats, idle at random, hold until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(step_stack(in_data));
        beats_sent++;
      end
      if (!in_valid || in_ready) begin
        send_now = (pending_beats.size() != 0) &&
                   ((beats_sent >= QuietFirst && beats_sent < QuietLast) ||
                    $urandom_range(99) >= IdlePct);
        // Pause until every outstanding result has come back
        if (send_now && pending_drain[0] && (in_valid || expected_results.size() != 0))
          send_now = 1'b0;
        if (send_now) begin
          in_data  <= pending_beats.pop_front();
          void'(pending_drain.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected result beat: max=%0d empty=%0b depth=%0d status=%0d",
                     out_data.current_max, out_data.is_empty, out_data.depth_used,
                     out_data.status);
        end else begin
          want = expected_results.pop_front();
          if (out_data.current_max !== want.current_max ||
              out_data.is_empty !== want.is_empty ||
              out_data.depth_used !== want.depth_used ||
              out_data.status !== want.status) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display({"result %0d mismatch: max=%0d/%0d empty=%0b/%0b ",
                        "depth=%0d/%0d status=%0d/%0d (got/exp)"},
                       results_seen, out_data.current_max, want.current_max,
                       out_data.is_empty, want.is_empty, out_data.depth_used,
                       want.depth_used, out_data.status, want.status);
          end
        end
      end
      // Hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && results_seen >= HoldOffAt) begin
        held_once = 1'b1;
        hold_left = HoldOffCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= QuietFirst && results_seen < QuietLast) ||
                     ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("max_tracking_stack_top_test: FAIL");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    // Directed: empty pops, extremes, repeated maxima, pops down to empty
    queue_beat(mts_pkg::KIND_POP,  32'shFFFF_FFFF, 1'b0);
    queue_beat(mts_pkg::KIND_PUSH, 32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, ValMin,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, ValMax,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, ValMax,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, 32'sd5,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  ValMax,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  ValMin,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, -32'sd1,        1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'shAAAA_AAAA, 1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh5555_5555, 1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, ValMin,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, ValMin,         1'b0);
    queue_beat(mts_pkg::KIND_PUSH, 32'shAAAA_AAAA, 1'b0);
    queue_beat(mts_pkg::KIND_PUSH, 32'sh5555_5555, 1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);
    queue_beat(mts_pkg::KIND_POP,  32'sh0,         1'b0);

    // Random: wander near empty, climb to full, push against full, fall back
    queue_random(50, 1'b1);
    for (int i = 0; i < 150; i++) queue_random(50, 1'b0);
    while (plan_depth < StackDepth) queue_random(92, 1'b0);
    for (int i = 0; i < 40; i++) queue_random(65, 1'b0);
    queue_random(20, 1'b1);
    for (int i = 0; i < 60; i++) queue_random(20, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("max_tracking_stack_top_test: PASS");
    end else begin
      $display("max_tracking_stack_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/max_tracking_stack_top.sv
tb/max_tracking_stack_top_test.sv
